// ===== sv/dbss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbss_pkg - shared types and constants for the block scan statistics engine
// Block geometry, header codes, mode and status codes, queue record type.
// ----------------------------------------------------------------------------
package dbss_pkg;

    // Block geometry
    localparam int BLOCK_WORDS = 128;
    localparam int POS_W       = $clog2(BLOCK_WORDS);

    // Counters saturate at 2^COUNT_BITS - 1, capped at 16 bits
    localparam int COUNT_BITS  = 16;
    localparam int OUT_CNT_W   = 16;
    localparam int CNT_W       = (COUNT_BITS < OUT_CNT_W) ? COUNT_BITS : OUT_CNT_W;

    // Header and secondary type codes
    localparam logic [31:0] HDR_TYPE    = 32'd2;
    localparam logic [31:0] SEC_ROOT    = 32'd1;
    localparam logic [31:0] SEC_USERDIR = 32'd2;
    localparam logic [31:0] SEC_FILE    = 32'hFFFF_FFFD;

    // Mode register codes
    localparam logic [1:0] MODE_REPAIR = 2'd0;
    localparam logic [1:0] MODE_COPY   = 2'd1;
    localparam logic [1:0] MODE_WALK   = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
    localparam logic [1:0] ST_SIZE_ERR    = 2'd2;

    // Queue depth between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified block end / image end
    typedef struct packed {
        logic       ck;     // word sum is zero
        logic       hdr;    // first word was header type
        logic       sec;    // last word is a plausible secondary type
        logic       ends;   // block completed on this word
        logic       last;   // final word of the image
        logic [1:0] mode;   // mode in force for this word
    } t_rec;

endpackage
`default_nettype wire

// ===== sv/dbss_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbss_front - word intake and block classification
// Tracks position and running sum; emits one record per block end or image end.
// ----------------------------------------------------------------------------
module dbss_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [31:0]          i_data_word,
    input  wire logic                 i_last_of_image,
    input  wire logic [1:0]           i_salvage_mode,
    output logic                      o_push,
    output dbss_pkg::t_rec            o_rec,
    input  wire logic                 i_full
);

    logic [dbss_pkg::POS_W-1:0] r_pos, n_pos;
    logic [31:0]                r_sum, n_sum;
    logic                       r_fwh, n_fwh;

    logic        accept;
    logic        ends;
    logic        fwh_eff;
    logic [31:0] sum_new;

    assign o_in_stall = i_full;
    assign accept     = i_in_valid & ~i_full;

    assign ends    = (r_pos == dbss_pkg::POS_W'(dbss_pkg::BLOCK_WORDS - 1));
    assign fwh_eff = (r_pos == '0) ? (i_data_word == dbss_pkg::HDR_TYPE) : r_fwh;
    assign sum_new = r_sum + i_data_word;

    assign o_push    = accept & (ends | i_last_of_image);
    assign o_rec.ck  = (sum_new == 32'd0);
    assign o_rec.hdr = fwh_eff;
    assign o_rec.sec = (i_data_word == dbss_pkg::SEC_ROOT)
                     | (i_data_word == dbss_pkg::SEC_USERDIR)
                     | (i_data_word == dbss_pkg::SEC_FILE);
    assign o_rec.ends = ends;
    assign o_rec.last = i_last_of_image;
    assign o_rec.mode = i_salvage_mode;

    always_comb begin
        n_pos = r_pos;
        n_sum = r_sum;
        n_fwh = r_fwh;
        if (accept) begin
            if (ends | i_last_of_image) begin
                n_pos = '0;
                n_sum = '0;
                n_fwh = 1'b0;
            end else begin
                n_pos = r_pos + 1'b1;
                n_sum = sum_new;
                n_fwh = fwh_eff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_sum <= '0;
            r_fwh <= 1'b0;
        end else begin
            r_pos <= n_pos;
            r_sum <= n_sum;
            r_fwh <= n_fwh;
        end
    end

endmodule
`default_nettype wire

// ===== sv/dbss_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbss_fifo - short record queue between front and back
// Register-based queue of classified records.
// ----------------------------------------------------------------------------
module dbss_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire dbss_pkg::t_rec i_rec,
    output logic                o_full,
    input  wire logic           i_pop,
    output dbss_pkg::t_rec      o_rec,
    output logic                o_empty
);

    dbss_pkg::t_rec                r_mem [dbss_pkg::QUEUE_DEPTH];
    logic [dbss_pkg::QPTR_W-1:0]   r_wptr, n_wptr;
    logic [dbss_pkg::QPTR_W-1:0]   r_rptr, n_rptr;
    logic [dbss_pkg::QCNT_W-1:0]   r_cnt,  n_cnt;

    assign o_full  = (r_cnt == dbss_pkg::QCNT_W'(dbss_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rec   = r_mem[r_rptr];

    function automatic logic [dbss_pkg::QPTR_W-1:0] f_inc(
        input logic [dbss_pkg::QPTR_W-1:0] p
    );
        if (p == dbss_pkg::QPTR_W'(dbss_pkg::QUEUE_DEPTH - 1)) return '0;
        return p + 1'b1;
    endfunction

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) n_wptr = f_inc(r_wptr);
        if (i_pop)  n_rptr = f_inc(r_rptr);
        if (i_push & ~i_pop)      n_cnt = r_cnt + 1'b1;
        else if (~i_push & i_pop) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// ===== sv/dbss_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbss_back - per-image counters and result register
// Applies mode rules to each record, bumps saturating counters, drives result.
// ----------------------------------------------------------------------------
module dbss_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire dbss_pkg::t_rec                  i_rec,
    input  wire logic                            i_empty,
    output logic                                 o_pop,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic                                 o_block_checksum_ok,
    output logic                                 o_block_is_header,
    output logic                                 o_block_header_valid,
    output logic [dbss_pkg::OUT_CNT_W-1:0]       o_total_blocks,
    output logic [dbss_pkg::OUT_CNT_W-1:0]       o_good_checksum_blocks,
    output logic [dbss_pkg::OUT_CNT_W-1:0]       o_header_count,
    output logic [dbss_pkg::OUT_CNT_W-1:0]       o_valid_header_count,
    output logic                                 o_image_done,
    output logic [1:0]                           o_status
);

    localparam int W = dbss_pkg::CNT_W;

    logic [W-1:0] r_blk, n_blk;
    logic [W-1:0] r_good, n_good;
    logic [W-1:0] r_hdr, n_hdr;
    logic [W-1:0] r_vhdr, n_vhdr;

    logic         r_valid;
    logic         r_ck, r_ih, r_hv, r_done;
    logic [1:0]   r_status;
    logic [W-1:0] r_o_blk, r_o_good, r_o_hdr, r_o_vhdr;

    logic       take;
    logic       supported, walk, counted, ck, ih, hv, partial;
    logic [1:0] status;

    function automatic logic [W-1:0] f_bump(input logic [W-1:0] c, input logic en);
        if (en && (c != '1)) return c + 1'b1;
        return c;
    endfunction

    assign take  = ~r_valid | ~i_out_stall;
    assign o_pop = take & ~i_empty;

    assign supported = (i_rec.mode == dbss_pkg::MODE_COPY)
                     | (i_rec.mode == dbss_pkg::MODE_WALK);
    assign walk      = (i_rec.mode == dbss_pkg::MODE_WALK);
    assign counted   = i_rec.ends & supported;
    assign ck        = counted & i_rec.ck;
    assign ih        = counted & walk & i_rec.hdr;
    assign hv        = ih & i_rec.ck & i_rec.sec;
    assign partial   = i_rec.last & ~i_rec.ends;

    // Size error wins over unsupported mode
    always_comb begin
        priority if (partial) status = dbss_pkg::ST_SIZE_ERR;
        else if (!supported)  status = dbss_pkg::ST_UNSUPPORTED;
        else                  status = dbss_pkg::ST_OK;
    end

    always_comb begin
        n_blk  = f_bump(r_blk,  counted);
        n_good = f_bump(r_good, ck);
        n_hdr  = f_bump(r_hdr,  ih);
        n_vhdr = f_bump(r_vhdr, hv);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_blk   <= '0;
            r_good  <= '0;
            r_hdr   <= '0;
            r_vhdr  <= '0;
        end else begin
            if (take) r_valid <= ~i_empty;
            if (o_pop) begin
                if (i_rec.last) begin
                    r_blk  <= '0;
                    r_good <= '0;
                    r_hdr  <= '0;
                    r_vhdr <= '0;
                end else begin
                    r_blk  <= n_blk;
                    r_good <= n_good;
                    r_hdr  <= n_hdr;
                    r_vhdr <= n_vhdr;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ck     <= ck;
            r_ih     <= ih;
            r_hv     <= hv;
            r_done   <= i_rec.last;
            r_status <= status;
            r_o_blk  <= n_blk;
            r_o_good <= n_good;
            r_o_hdr  <= n_hdr;
            r_o_vhdr <= n_vhdr;
        end
    end

    assign o_out_valid            = r_valid;
    assign o_block_checksum_ok    = r_ck;
    assign o_block_is_header      = r_ih;
    assign o_block_header_valid   = r_hv;
    assign o_total_blocks         = dbss_pkg::OUT_CNT_W'(r_o_blk);
    assign o_good_checksum_blocks = dbss_pkg::OUT_CNT_W'(r_o_good);
    assign o_header_count         = dbss_pkg::OUT_CNT_W'(r_o_hdr);
    assign o_valid_header_count   = dbss_pkg::OUT_CNT_W'(r_o_vhdr);
    assign o_image_done           = r_done;
    assign o_status               = r_status;

endmodule
`default_nettype wire

// ===== sv/disk_block_scan_stats_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// disk_block_scan_stats_top - disk image block checksum scanner, top level
// Streams image words, checks block sums and header types, keeps image totals.
// ----------------------------------------------------------------------------
// One word is taken per clock while the queue has room: the front end holds
// only the block position, the 32-bit running sum and the header flag, so
// the single add-and-compare on the running sum sets the pace. A result
// transaction follows the word that ends a 512-byte block or the image,
// passing through the queue and the result register (front end -> queue
// -> result register). Input stalls only when the two-entry queue is full,
// i.e. when the consumer has held its stall long enough to back everything
// up. Counters are per image, saturate at 65535 and restart after the result
// flagged image_done. An image ending part-way through a block gives status
// 2 and the partial block is dropped; repair mode (or the unused code 3)
// counts nothing and reports status 1. Write salvage_mode only while idle;
// the config channel is always ready.
// ----------------------------------------------------------------------------
module disk_block_scan_stats_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // config write transaction
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [1:0]                  i_cfg_salvage_mode,
    // input word transaction
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [31:0]                 i_data_word,
    input  wire logic                        i_last_of_image,
    // result transaction
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic                             o_block_checksum_ok,
    output logic                             o_block_is_header,
    output logic                             o_block_header_valid,
    output logic [dbss_pkg::OUT_CNT_W-1:0]   o_total_blocks,
    output logic [dbss_pkg::OUT_CNT_W-1:0]   o_good_checksum_blocks,
    output logic [dbss_pkg::OUT_CNT_W-1:0]   o_header_count,
    output logic [dbss_pkg::OUT_CNT_W-1:0]   o_valid_header_count,
    output logic                             o_image_done,
    output logic [1:0]                       o_status
);

    // Mode register, resets to file walk
    logic [1:0] r_salvage_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_salvage_mode <= dbss_pkg::MODE_WALK;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_salvage_mode <= i_cfg_salvage_mode;
        end
    end

    assign o_cfg_ready = 1'b1;

    // front -> queue -> back
    dbss_pkg::t_rec push_rec, pop_rec;
    logic           push, full, pop, empty;

    // Front: position/sum tracking, mode sampled per word
    dbss_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_word     (i_data_word),
        .i_last_of_image (i_last_of_image),
        .i_salvage_mode  (r_salvage_mode),
        .o_push          (push),
        .o_rec           (push_rec),
        .i_full          (full)
    );

    // Decoupling queue
    dbss_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .o_full  (full),
        .i_pop   (pop),
        .o_rec   (pop_rec),
        .o_empty (empty)
    );

    // Back: counters and result register
    dbss_back u_back (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_rec                  (pop_rec),
        .i_empty                (empty),
        .o_pop                  (pop),
        .o_out_valid            (o_out_valid),
        .i_out_stall            (i_out_stall),
        .o_block_checksum_ok    (o_block_checksum_ok),
        .o_block_is_header      (o_block_is_header),
        .o_block_header_valid   (o_block_header_valid),
        .o_total_blocks         (o_total_blocks),
        .o_good_checksum_blocks (o_good_checksum_blocks),
        .o_header_count         (o_header_count),
        .o_valid_header_count   (o_valid_header_count),
        .o_image_done           (o_image_done),
        .o_status               (o_status)
    );

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - block checksum scan statistics engine, self-checking bench
// Streams disk image words with random gaps and result back-pressure, runs a
// cycle-free scoreboard model of the block scanner and compares every result
// transaction field by field. A directed table comes first, then random
// images of fragments and blocks (half well-formed headers), under every mode code.
// ----------------------------------------------------------------------------
module testbench;

    // Mode code 3 is not defined by the block; it must behave as repair
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int RANDOM_WORDS   = 1150;  // random words before stopping
    localparam int SETTLE_CYCLES  = 4;     // pipeline is two deep, plus margin
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all

    localparam logic [15:0] CNT_MAX = 16'((32'd1 << dbss_pkg::CNT_W) - 1);

    typedef struct packed {
        logic        ck;
        logic        hdr;
        logic        hv;
        logic [15:0] total;
        logic [15:0] good;
        logic [15:0] headers;
        logic [15:0] valid_hdrs;
        logic        done;
        logic [1:0]  status;
    } t_scan_result;

    // One directed word; exp is only used where typed is set
    typedef struct packed {
        logic [1:0]   mode;
        logic [31:0]  word;
        logic         last;
        logic         typed;
        t_scan_result exp;
    } t_dir_row;

    // Image cut short before any whole block: nothing counted, size error
    localparam t_scan_result SIZE_ERR_EMPTY = '{ck: 1'b0, hdr: 1'b0, hv: 1'b0,
        total: 16'd0, good: 16'd0, headers: 16'd0, valid_hdrs: 16'd0,
        done: 1'b1, status: dbss_pkg::ST_SIZE_ERR};
    localparam t_scan_result NO_TYPED = '0;

    localparam int DIRECTED_ROWS = 15;
    localparam t_dir_row directed_rows [DIRECTED_ROWS] = '{
        // all-zero and all-ones single-word images
        '{dbss_pkg::MODE_WALK,   32'h0000_0000,         1'b1, 1'b1, SIZE_ERR_EMPTY},
        '{dbss_pkg::MODE_WALK,   32'hFFFF_FFFF,         1'b1, 1'b1, SIZE_ERR_EMPTY},
        // header start with file secondary, but partial: dropped
        '{dbss_pkg::MODE_WALK,   dbss_pkg::HDR_TYPE,    1'b0, 1'b0, NO_TYPED},
        '{dbss_pkg::MODE_WALK,   dbss_pkg::SEC_FILE,    1'b1, 1'b1, SIZE_ERR_EMPTY},
        '{dbss_pkg::MODE_COPY,   dbss_pkg::HDR_TYPE,    1'b0, 1'b0, NO_TYPED},
        '{dbss_pkg::MODE_COPY,   dbss_pkg::SEC_ROOT,    1'b1, 1'b1, SIZE_ERR_EMPTY},
        // size error wins over unsupported mode
        '{dbss_pkg::MODE_REPAIR, 32'h0000_0005,         1'b1, 1'b1, SIZE_ERR_EMPTY},
        '{MODE_UNUSED,           32'hAAAA_AAAA,         1'b0, 1'b0, NO_TYPED},
        '{MODE_UNUSED,           32'h5555_5555,         1'b1, 1'b1, SIZE_ERR_EMPTY},
        '{dbss_pkg::MODE_REPAIR, 32'hFFFF_FFFF,         1'b0, 1'b0, NO_TYPED},
        '{dbss_pkg::MODE_REPAIR, 32'h0000_0000,         1'b0, 1'b0, NO_TYPED},
        '{dbss_pkg::MODE_REPAIR, dbss_pkg::SEC_ROOT,    1'b1, 1'b1, SIZE_ERR_EMPTY},
        '{dbss_pkg::MODE_WALK,   32'h8000_0000,         1'b0, 1'b0, NO_TYPED},
        '{dbss_pkg::MODE_WALK,   32'h7FFF_FFFF,         1'b0, 1'b0, NO_TYPED},
        '{dbss_pkg::MODE_WALK,   dbss_pkg::SEC_USERDIR, 1'b1, 1'b1, SIZE_ERR_EMPTY}
    };

    // ------------------------------------------------------------------
    // DUT signals, all inputs driven to known values from time zero
    // ------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_salvage_mode = dbss_pkg::MODE_WALK;
    logic        i_in_valid = 1'b0;
    logic [31:0] i_data_word = '0;
    logic        i_last_of_image = 1'b0;
    logic        i_out_stall = 1'b1;
    logic        o_cfg_ready;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_block_checksum_ok;
    logic        o_block_is_header;
    logic        o_block_header_valid;
    logic [dbss_pkg::OUT_CNT_W-1:0] o_total_blocks;
    logic [dbss_pkg::OUT_CNT_W-1:0] o_good_checksum_blocks;
    logic [dbss_pkg::OUT_CNT_W-1:0] o_header_count;
    logic [dbss_pkg::OUT_CNT_W-1:0] o_valid_header_count;
    logic        o_image_done;
    logic [1:0]  o_status;

    disk_block_scan_stats_top dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_salvage_mode     (i_cfg_salvage_mode),
        .i_in_valid             (i_in_valid),
        .o_in_stall             (o_in_stall),
        .i_data_word            (i_data_word),
        .i_last_of_image        (i_last_of_image),
        .o_out_valid            (o_out_valid),
        .i_out_stall            (i_out_stall),
        .o_block_checksum_ok    (o_block_checksum_ok),
        .o_block_is_header      (o_block_is_header),
        .o_block_header_valid   (o_block_header_valid),
        .o_total_blocks         (o_total_blocks),
        .o_good_checksum_blocks (o_good_checksum_blocks),
        .o_header_count         (o_header_count),
        .o_valid_header_count   (o_valid_header_count),
        .o_image_done           (o_image_done),
        .o_status               (o_status)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Scan model state: mirrors the register and the per-image counters
    // ------------------------------------------------------------------
    logic [1:0]   scan_mode = dbss_pkg::MODE_WALK;
    int           scan_pos = 0;
    logic [31:0]  scan_sum = '0;
    logic         scan_first_hdr = 1'b0;
    logic [15:0]  cnt_blocks = '0;
    logic [15:0]  cnt_good = '0;
    logic [15:0]  cnt_headers = '0;
    logic [15:0]  cnt_valid_hdrs = '0;

    t_scan_result pending_stats [$];   // expected results, oldest first
    logic [32:0]  image_words [$];     // {last, word} of the image in hand
    int           words_sent = 0;
    int           errors = 0;
    int           quiet_cycles = 0;
    bit           tx_burst = 1'b0;     // sender runs without gaps
    bit           rx_burst = 1'b0;     // receiver never stalls

    function automatic logic [15:0] sat_inc(input logic [15:0] c);
        return (c < CNT_MAX) ? c + 16'd1 : c;
    endfunction

    // Consumes one word; returns 1 with the stats when the word ends a block
    // or the image.
    function automatic bit scan_stats_predict(input logic [31:0] w, input logic last,
                                              output t_scan_result r);
        bit supported;
        bit walk;
        bit ends;
        bit sec;
        supported = (scan_mode == dbss_pkg::MODE_COPY) || (scan_mode == dbss_pkg::MODE_WALK);
        walk      = (scan_mode == dbss_pkg::MODE_WALK);
        ends      = (scan_pos >= dbss_pkg::BLOCK_WORDS - 1);
        r         = '0;
        if (scan_pos == 0)
            scan_first_hdr = (w == dbss_pkg::HDR_TYPE);
        scan_sum += w;
        if (ends) begin
            if (supported) begin
                r.ck = (scan_sum == 32'd0);
                cnt_blocks = sat_inc(cnt_blocks);
                if (r.ck)
                    cnt_good = sat_inc(cnt_good);
                if (walk && scan_first_hdr) begin
                    sec = (w == dbss_pkg::SEC_ROOT) || (w == dbss_pkg::SEC_USERDIR)
                          || (w == dbss_pkg::SEC_FILE);
                    r.hdr = 1'b1;
                    cnt_headers = sat_inc(cnt_headers);
                    if (r.ck && sec) begin
                        r.hv = 1'b1;
                        cnt_valid_hdrs = sat_inc(cnt_valid_hdrs);
                    end
                end
            end
            scan_pos       = 0;
            scan_sum       = '0;
            scan_first_hdr = 1'b0;
        end else begin
            scan_pos++;
        end
        if (!ends && !last)
            return 1'b0;
        if (last && !ends)
            r.status = dbss_pkg::ST_SIZE_ERR;
        else if (!supported)
            r.status = dbss_pkg::ST_UNSUPPORTED;
        else
            r.status = dbss_pkg::ST_OK;
        r.total      = cnt_blocks;
        r.good       = cnt_good;
        r.headers    = cnt_headers;
        r.valid_hdrs = cnt_valid_hdrs;
        r.done       = last;
        if (last) begin
            scan_pos       = 0;
            scan_sum       = '0;
            scan_first_hdr = 1'b0;
            cnt_blocks     = '0;
            cnt_good       = '0;
            cnt_headers    = '0;
            cnt_valid_hdrs = '0;
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generators
    // ------------------------------------------------------------------
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return dbss_pkg::HDR_TYPE;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_secondary();
        case ($urandom_range(0, 2))
            0:       return dbss_pkg::SEC_ROOT;
            1:       return dbss_pkg::SEC_USERDIR;
            default: return dbss_pkg::SEC_FILE;
        endcase
    endfunction

    // Appends one whole block. Half the time a header with a plausible secondary
    // and zero sum; otherwise one of those, or both secondary and sum, are broken.
    task automatic add_block();
        logic [31:0] blk [dbss_pkg::BLOCK_WORDS];
        logic [31:0] sum;
        int          kind;
        int          fix;
        bit          want_hdr;
        bit          want_sec;
        bit          want_zero;
        kind      = $urandom_range(0, 7);
        want_hdr  = (kind <= 5);
        want_sec  = (kind != 5) && (kind != 7);
        want_zero = (kind != 4) && (kind != 7);
        foreach (blk[i])
            blk[i] = pick_word();
        if (want_hdr)
            blk[0] = dbss_pkg::HDR_TYPE;
        else if (kind == 6 && blk[0] == dbss_pkg::HDR_TYPE)
            blk[0] = 32'h0000_0008;
        if (want_sec) begin
            blk[dbss_pkg::BLOCK_WORDS-1] = pick_secondary();
        end else if (blk[dbss_pkg::BLOCK_WORDS-1] == dbss_pkg::SEC_ROOT
                     || blk[dbss_pkg::BLOCK_WORDS-1] == dbss_pkg::SEC_USERDIR
                     || blk[dbss_pkg::BLOCK_WORDS-1] == dbss_pkg::SEC_FILE) begin
            blk[dbss_pkg::BLOCK_WORDS-1] ^= 32'h0000_0010;
        end
        // balance one middle word so that the block sums to zero (or not)
        fix      = $urandom_range(1, dbss_pkg::BLOCK_WORDS - 2);
        blk[fix] = '0;
        sum      = '0;
        foreach (blk[i])
            sum += blk[i];
        if (want_zero)
            blk[fix] = -sum;
        else if (sum == 32'd0)
            blk[fix] = 32'd1;
        foreach (blk[i])
            image_words.push_back({1'b0, blk[i]});
    endtask

    // Short fragments (size error) or one to two blocks with an optional tail
    task automatic build_image();
        int tail;
        image_words.delete();
        if ($urandom_range(0, 9) < 6) begin
            tail = $urandom_range(1, 24);
        end else begin
            add_block();
            if ($urandom_range(0, 3) == 0)
                add_block();
            case ($urandom_range(0, 3))
                0:       tail = $urandom_range(1, dbss_pkg::BLOCK_WORDS - 1);
                1:       tail = $urandom_range(1, 8);
                default: tail = 0;
            endcase
        end
        repeat (tail)
            image_words.push_back({1'b0, pick_word()});
        image_words[image_words.size()-1][32] = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Input side: one word transaction, with a random gap before it.
    // Valid is only lowered when a gap follows, so no step sees it both
    // dropped and raised.
    // ------------------------------------------------------------------
    task automatic send_word(input logic [31:0] w, input logic last,
                             input logic typed, input t_scan_result typed_exp);
        int           gap;
        t_scan_result r;
        gap = tx_burst ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_data_word     <= w;
        i_last_of_image <= last;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        words_sent++;
        if (scan_stats_predict(w, last, r))
            pending_stats.push_back(typed ? typed_exp : r);
    endtask

    // Holds the sender until every expected result has been taken
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mode register write, only with the pipeline empty
    task automatic write_mode(input logic [1:0] m);
        drain_results();
        i_cfg_valid        <= 1'b1;
        i_cfg_salvage_mode <= m;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        scan_mode = m;
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset, directed table, then random phases. Each phase
    // writes a mode and sends a few whole images; the first four phases
    // visit every mode code, later ones lean towards file walk.
    // ------------------------------------------------------------------
    initial begin : stimulus
        int         phase;
        logic [1:0] m;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (directed_rows[i].mode != scan_mode)
                write_mode(directed_rows[i].mode);
            send_word(directed_rows[i].word, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].exp);
        end

        phase = 0;
        while (words_sent < DIRECTED_ROWS + RANDOM_WORDS) begin
            case (phase)
                0: m = dbss_pkg::MODE_COPY;
                1: m = dbss_pkg::MODE_REPAIR;
                2: m = MODE_UNUSED;
                3: m = dbss_pkg::MODE_WALK;
                default: begin
                    case ($urandom_range(0, 7))
                        0:       m = dbss_pkg::MODE_REPAIR;
                        1:       m = MODE_UNUSED;
                        2, 3:    m = dbss_pkg::MODE_COPY;
                        default: m = dbss_pkg::MODE_WALK;
                    endcase
                end
            endcase
            write_mode(m);
            repeat ($urandom_range(1, 4)) begin
                if (words_sent < DIRECTED_ROWS + RANDOM_WORDS) begin
                    build_image();
                    tx_burst = ($urandom_range(0, 3) == 0);
                    foreach (image_words[k])
                        send_word(image_words[k][31:0], image_words[k][32], 1'b0, NO_TYPED);
                    // occasionally let everything drain between images
                    if ($urandom_range(0, 7) == 0)
                        drain_results();
                end
            end
            phase++;
        end

        // wind down: nothing more to send, wait for the stragglers
        drain_results();
        repeat (4 * SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random stall before each transaction, then compare the
    // accepted transaction with the oldest expectation.
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] exp,
                                        input logic [31:0] act);
        if (act !== exp) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp, act);
            errors++;
        end
    endfunction

    initial begin : result_monitor
        int           hold;
        t_scan_result e;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 31) == 0)
                rx_burst = !rx_burst;
            hold = rx_burst ? 0 : $urandom_range(0, 15);
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
            if (pending_stats.size() == 0) begin
                $error("result transaction with no expectation waiting");
                errors++;
            end else begin
                e = pending_stats.pop_front();
                check_field("block_checksum_ok",    32'(e.ck),   32'(o_block_checksum_ok));
                check_field("block_is_header",      32'(e.hdr),  32'(o_block_is_header));
                check_field("block_header_valid",   32'(e.hv),   32'(o_block_header_valid));
                check_field("total_blocks",         32'(e.total), 32'(o_total_blocks));
                check_field("good_checksum_blocks", 32'(e.good), 32'(o_good_checksum_blocks));
                check_field("header_count",         32'(e.headers), 32'(o_header_count));
                check_field("valid_header_count",   32'(e.valid_hdrs),
                            32'(o_valid_header_count));
                check_field("image_done",           32'(e.done), 32'(o_image_done));
                check_field("status",               32'(e.status), 32'(o_status));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any transaction on any channel resets the quiet count
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
